// ===== sv/csort_pkg.sv =====
// shared types and constants of the cocktail shaker sorter
`timescale 1ns / 1ps
`default_nettype none
package csort_pkg;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_BWD = 1'b1;

	typedef struct packed {
		logic swap;
	} cs_flags_t;

endpackage
`default_nettype wire

// ===== sv/csort_cs_unit.sv =====
// compare-swap unit shared by forward and backward passes
`timescale 1ns / 1ps
`default_nettype none
module csort_cs_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   dir,
	input  wire logic [VALUE_WIDTH-1:0] cur,
	input  wire logic [VALUE_WIDTH-1:0] other,
	output csort_pkg::cs_flags_t        flags,
	output logic      [VALUE_WIDTH-1:0] wr_val,
	output logic      [VALUE_WIDTH-1:0] carry_val
);

	logic [VALUE_WIDTH-1:0] op_a;
	logic [VALUE_WIDTH-1:0] op_b;
	logic                   a_gt_b;

	// forward carries the max, backward carries the min
	assign op_a   = (dir == csort_pkg::DIR_FWD) ? cur : other;
	assign op_b   = (dir == csort_pkg::DIR_FWD) ? other : cur;
	assign a_gt_b = $signed(op_a) > $signed(op_b);

	assign flags.swap = a_gt_b;
	assign wr_val     = a_gt_b ? other : cur;
	assign carry_val  = a_gt_b ? cur : other;

endmodule
`default_nettype wire

// ===== sv/cocktail_shaker_sorter_top.sv =====
// cocktail shaker sorter: list load, in-place sort and ordered readout
// Loads up to MAX_ELEMENTS signed values, one per item; the item flagged last ends
// the list (values past capacity are dropped, the last flag still counts). The list
// is then sorted ascending in a single-port-write, single-port-read store by one
// shared compare-swap unit: each compare-swap reads the store, then compares and
// writes back; each pass walks the neighbor pairs between the current bounds,
// and sorting ends after the first round without a swap. Each value is read out
// via a store read and the output register, then waits for out_ready; the next
// is read once it is taken. in_ready is high only while a list is being loaded.
`timescale 1ns / 1ps
`default_nettype none
module cocktail_shaker_sorter_top #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [VALUE_WIDTH-1:0] sorted_value,
	output logic                        end_of_list
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_ROUND = 4'd1;
	localparam logic [3:0] S_PASS  = 4'd2;
	localparam logic [3:0] S_LDCUR = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_TAIL  = 4'd6;
	localparam logic [3:0] S_ORD   = 4'd7;
	localparam logic [3:0] S_OLD   = 4'd8;
	localparam logic [3:0] S_OWAIT = 4'd9;

	logic [3:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          lo_q;
	logic [AW-1:0]          hi_q;
	logic [AW-1:0]          i_q;
	logic [AW-1:0]          k_q;
	logic                   dir_q;
	logic                   moved_q;
	logic [VALUE_WIDTH-1:0] cur_q;
	logic [VALUE_WIDTH-1:0] rdata_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_last_q;

	logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

	logic                   in_acc;
	logic                   has_room;
	logic [CW-1:0]          cnt_next;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [VALUE_WIDTH-1:0] wdata;
	logic [AW-1:0]          raddr;
	logic [AW-1:0]          i_step;
	logic                   k_is_last;

	csort_pkg::cs_flags_t   cs_flags;
	logic [VALUE_WIDTH-1:0] cs_wr;
	logic [VALUE_WIDTH-1:0] cs_carry;

	csort_cs_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_cs (
		.dir      (dir_q),
		.cur      (cur_q),
		.other    (rdata_q),
		.flags    (cs_flags),
		.wr_val   (cs_wr),
		.carry_val(cs_carry)
	);

	assign in_ready  = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign has_room  = cnt_q < CW'(MAX_ELEMENTS);
	assign cnt_next  = has_room ? cnt_q + CW'(1) : cnt_q;
	assign i_step    = (dir_q == csort_pkg::DIR_FWD) ? i_q + AW'(1) : i_q - AW'(1);
	assign k_is_last = CW'(k_q) == cnt_q - CW'(1);

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = value;
		raddr = i_q;
		unique case (state_q)
			S_LOAD: begin
				we = in_acc && has_room;
			end
			S_RD: begin
				raddr = i_step;
			end
			S_CMP: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = cs_wr;
			end
			S_TAIL: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = cur_q;
			end
			S_ORD: begin
				raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	// element store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			k_q         <= '0;
			dir_q       <= csort_pkg::DIR_FWD;
			moved_q     <= 1'b0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						if (last) begin
							lo_q <= '0;
							hi_q <= AW'(cnt_next - CW'(1));
							k_q  <= '0;
							if (cnt_next > CW'(1)) begin
								state_q <= S_ROUND;
							end else begin
								state_q <= S_ORD;
							end
						end
					end
				end
				S_ROUND: begin
					moved_q <= 1'b0;
					i_q     <= lo_q;
					dir_q   <= csort_pkg::DIR_FWD;
					if (lo_q < hi_q) begin
						state_q <= S_PASS;
					end else begin
						state_q <= S_ORD;
					end
				end
				S_PASS: begin
					state_q <= S_LDCUR;
				end
				S_LDCUR: begin
					cur_q   <= rdata_q;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					cur_q <= cs_carry;
					i_q   <= i_step;
					if (cs_flags.swap) begin
						moved_q <= 1'b1;
					end
					if ((dir_q == csort_pkg::DIR_FWD && i_step == hi_q) ||
					    (dir_q == csort_pkg::DIR_BWD && i_step == lo_q)) begin
						state_q <= S_TAIL;
					end else begin
						state_q <= S_RD;
					end
				end
				S_TAIL: begin
					if (dir_q == csort_pkg::DIR_FWD) begin
						hi_q  <= hi_q - AW'(1);
						i_q   <= hi_q - AW'(1);
						dir_q <= csort_pkg::DIR_BWD;
						if (hi_q - AW'(1) > lo_q) begin
							state_q <= S_PASS;
						end else begin
							state_q <= S_ORD;
						end
					end else begin
						lo_q <= lo_q + AW'(1);
						if (moved_q) begin
							state_q <= S_ROUND;
						end else begin
							state_q <= S_ORD;
						end
					end
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OWAIT;
				end
				S_OWAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (state_q == S_OLD) begin
			out_value_q <= rdata_q;
			out_last_q  <= k_is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign end_of_list  = out_last_q;

endmodule
`default_nettype wire
